### design/bpr_pkg.sv
// Package for the byte pipe ring FIFO: operation, status and command codes,
// field widths and the controller/datapath handshake structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpr_pkg;

  localparam int CAPACITY_DEF  = 512;
  localparam int MAX_BURST_DEF = 64;

  localparam int FUNC_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 7;
  localparam int STATUS_W = 3;
  localparam int FILL_W   = 10;

  // largest burst the avail status field can allow
  localparam int BURST_LIMIT = 64;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE    = 3'd0,
    FUNC_READ     = 3'd1,
    FUNC_CLOSE_RD = 3'd2,
    FUNC_CLOSE_WR = 3'd3,
    FUNC_CREATE   = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_EOF   = 3'd1,
    ST_BLOCK = 3'd2,
    ST_EPIPE = 3'd3,
    ST_BADF  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_RESULT,
    CMD_WRITE,
    CMD_READ,
    CMD_CLOSE_RD,
    CMD_CLOSE_WR,
    CMD_CREATE
  } cmd_op_t;

  typedef enum logic {
    S_IDLE,
    S_BURST
  } state_t;

  // controller -> datapath
  typedef struct packed {
    cmd_op_t          op;
    status_t          status;
    logic             last;
    logic [LEN_W-1:0] xfer;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic             reader_open;
    logic             writer_open;
    logic             empty;
    logic             full;
    logic [LEN_W-1:0] avail;  // buffered bytes, clipped to BURST_LIMIT
  } dp_stat_t;

endpackage

`default_nettype wire

### design/bpr_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

### design/bpr_ctrl.sv
// Controller for the byte pipe: decodes requests, checks end flags and
// fill state, and sequences read bursts one byte per cycle.
// Depends on bpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpr_ctrl #(
  parameter int MAX_BURST = bpr_pkg::MAX_BURST_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [bpr_pkg::FUNC_W-1:0]  func,
  input  wire logic [bpr_pkg::LEN_W-1:0]   req_len,
  input  wire bpr_pkg::dp_stat_t           stat,
  output bpr_pkg::cmd_t                    cmd
);
  import bpr_pkg::*;

  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] remain_r, remain_nxt;  // bytes still to issue
  logic [LEN_W-1:0] xfer_r, xfer_nxt;      // bytes issued so far
  logic [LEN_W-1:0] sat_len;
  logic [LEN_W-1:0] burst_len;

  assign sat_len   = (req_len > LEN_W'(MAX_BURST)) ? LEN_W'(MAX_BURST) : req_len;
  assign burst_len = (sat_len > stat.avail) ? stat.avail : sat_len;
  assign busy      = (state_r == S_BURST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      remain_r <= '0;
      xfer_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      remain_r <= remain_nxt;
      xfer_r   <= xfer_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    remain_nxt = remain_r;
    xfer_nxt   = xfer_r;
    cmd.op     = CMD_IDLE;
    cmd.status = ST_OK;
    cmd.last   = 1'b1;
    cmd.xfer   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op = CMD_RESULT;
          unique case (func)
            FUNC_WRITE: begin
              if (!stat.writer_open) begin
                cmd.status = ST_BADF;
              end else if (!stat.reader_open) begin
                cmd.status = ST_EPIPE;
              end else if (stat.full) begin
                cmd.status = ST_BLOCK;
              end else begin
                cmd.op   = CMD_WRITE;
                cmd.xfer = LEN_W'(1);
              end
            end
            FUNC_READ: begin
              if (!stat.reader_open) begin
                cmd.status = ST_BADF;
              end else if (req_len == '0) begin
                cmd.status = ST_OK;
              end else if (stat.empty) begin
                cmd.status = stat.writer_open ? ST_BLOCK : ST_EOF;
              end else begin
                // first byte goes out on the accepting edge
                cmd.op     = CMD_READ;
                cmd.xfer   = LEN_W'(1);
                cmd.last   = (burst_len == LEN_W'(1));
                remain_nxt = burst_len - LEN_W'(1);
                xfer_nxt   = LEN_W'(1);
                if (burst_len != LEN_W'(1)) begin
                  state_nxt = S_BURST;
                end
              end
            end
            FUNC_CLOSE_RD: begin
              if (!stat.reader_open) begin
                cmd.status = ST_BADF;
              end else begin
                cmd.op = CMD_CLOSE_RD;
              end
            end
            FUNC_CLOSE_WR: begin
              if (!stat.writer_open) begin
                cmd.status = ST_BADF;
              end else begin
                cmd.op = CMD_CLOSE_WR;
              end
            end
            FUNC_CREATE: begin
              cmd.op = CMD_CREATE;
            end
            default: begin
              cmd.status = ST_BADF;
            end
          endcase
        end
      end
      S_BURST: begin
        cmd.op     = CMD_READ;
        cmd.xfer   = xfer_r + LEN_W'(1);
        cmd.last   = (remain_r == LEN_W'(1));
        remain_nxt = remain_r - LEN_W'(1);
        xfer_nxt   = xfer_r + LEN_W'(1);
        if (remain_r == LEN_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/bpr_dpath.sv
// Datapath for the byte pipe: ring pointers, byte count, end flags,
// the ring memory and the result registers.
// Depends on bpr_pkg and bpr_ram.
`timescale 1ns / 1ps
`default_nettype none

module bpr_dpath #(
  parameter int CAPACITY = bpr_pkg::CAPACITY_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire bpr_pkg::cmd_t                cmd,
  input  wire logic [bpr_pkg::BYTE_W-1:0]   wr_byte,
  output bpr_pkg::dp_stat_t                 stat,
  output logic                              out_strobe,
  output logic [bpr_pkg::STATUS_W-1:0]      out_status,
  output logic [bpr_pkg::BYTE_W-1:0]        out_rd_data,
  output logic                              out_rd_valid,
  output logic                              out_last,
  output logic [bpr_pkg::LEN_W-1:0]         out_transfer_count,
  output logic [bpr_pkg::FILL_W-1:0]        out_fill_level
);
  import bpr_pkg::*;

  localparam int PTR_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt, rd_adv;
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt, wr_adv;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                reader_open_r, reader_open_nxt;
  logic                writer_open_r, writer_open_nxt;
  logic [31:0]         count_ext, count_nxt_ext;

  logic                ram_we;
  logic [PTR_W-1:0]    ram_addr;
  logic [BYTE_W-1:0]   ram_q;

  logic                strobe_r;
  logic [STATUS_W-1:0] status_r;
  logic                rd_valid_r;
  logic                last_r;
  logic [LEN_W-1:0]    xfer_r;
  logic [FILL_W-1:0]   fill_r;

  assign rd_adv = (rd_ptr_r == PTR_W'(CAPACITY - 1)) ? '0 : rd_ptr_r + 1'b1;
  assign wr_adv = (wr_ptr_r == PTR_W'(CAPACITY - 1)) ? '0 : wr_ptr_r + 1'b1;

  assign count_ext        = 32'(count_r);
  assign count_nxt_ext    = 32'(count_nxt);
  assign stat.reader_open = reader_open_r;
  assign stat.writer_open = writer_open_r;
  assign stat.empty       = (count_r == '0);
  assign stat.full        = (count_r == CNT_W'(CAPACITY));
  assign stat.avail       = (count_ext >= 32'(BURST_LIMIT)) ? LEN_W'(BURST_LIMIT)
                                                            : count_ext[LEN_W-1:0];

  always_comb begin
    rd_ptr_nxt      = rd_ptr_r;
    wr_ptr_nxt      = wr_ptr_r;
    count_nxt       = count_r;
    reader_open_nxt = reader_open_r;
    writer_open_nxt = writer_open_r;
    ram_we          = 1'b0;
    ram_addr        = rd_ptr_r;
    unique case (cmd.op)
      CMD_WRITE: begin
        ram_we     = 1'b1;
        ram_addr   = wr_ptr_r;
        wr_ptr_nxt = wr_adv;
        count_nxt  = count_r + 1'b1;
      end
      CMD_READ: begin
        rd_ptr_nxt = rd_adv;
        count_nxt  = count_r - 1'b1;
      end
      CMD_CLOSE_RD: reader_open_nxt = 1'b0;
      CMD_CLOSE_WR: writer_open_nxt = 1'b0;
      CMD_CREATE: begin
        rd_ptr_nxt      = '0;
        wr_ptr_nxt      = '0;
        count_nxt       = '0;
        reader_open_nxt = 1'b1;
        writer_open_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r      <= '0;
      wr_ptr_r      <= '0;
      count_r       <= '0;
      reader_open_r <= 1'b1;
      writer_open_r <= 1'b1;
      strobe_r      <= 1'b0;
    end else begin
      rd_ptr_r      <= rd_ptr_nxt;
      wr_ptr_r      <= wr_ptr_nxt;
      count_r       <= count_nxt;
      reader_open_r <= reader_open_nxt;
      writer_open_r <= writer_open_nxt;
      strobe_r      <= (cmd.op != CMD_IDLE);
    end
  end

  // result fields line up with the registered memory read
  always_ff @(posedge clk) begin
    status_r   <= cmd.status;
    rd_valid_r <= (cmd.op == CMD_READ);
    last_r     <= cmd.last;
    xfer_r     <= cmd.xfer;
    fill_r     <= count_nxt_ext[FILL_W-1:0];
  end

  bpr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (CAPACITY)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (wr_byte),
    .rdata (ram_q)
  );

  assign out_strobe         = strobe_r;
  assign out_status         = status_r;
  assign out_rd_valid       = rd_valid_r;
  assign out_rd_data        = rd_valid_r ? ram_q : '0;
  assign out_last           = last_r;
  assign out_transfer_count = xfer_r;
  assign out_fill_level     = fill_r;

endmodule

`default_nettype wire

### design/byte_pipe_ring_fifo_unit.sv
// Top level of the byte pipe: ring FIFO with reader/writer end flags.
// Depends on bpr_pkg, bpr_ctrl, bpr_dpath (which holds bpr_ram).
//
// Usage:
//   Requests enter on in_func / in_wr_byte / in_req_len and are taken on a
//   rising edge with start high and busy low. in_func selects write byte,
//   read burst, close read end, close write end or create.
//   Results leave on the out_ ports for exactly one cycle, flagged by
//   out_strobe; the receiver cannot stall them, it must take each one.
//   The first (or only) result shows in the cycle after the request is
//   taken. A read burst of n bytes gives n results in consecutive cycles,
//   the final one with out_last; busy stays high while the rest of the
//   burst is issued and no new request is taken, while every other request
//   leaves busy low. The single-port ring memory, read or written once per
//   cycle, limits the pipe to one byte per cycle.
//   Reset (rst_n low, synchronous): ring empty, pointers zero, both ends
//   open; ring contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module byte_pipe_ring_fifo_unit #(
  parameter int CAPACITY  = bpr_pkg::CAPACITY_DEF,
  parameter int MAX_BURST = bpr_pkg::MAX_BURST_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [bpr_pkg::FUNC_W-1:0]    in_func,
  input  wire logic [bpr_pkg::BYTE_W-1:0]    in_wr_byte,
  input  wire logic [bpr_pkg::LEN_W-1:0]     in_req_len,
  output logic                               out_strobe,
  output logic [bpr_pkg::STATUS_W-1:0]       out_status,
  output logic [bpr_pkg::BYTE_W-1:0]         out_rd_data,
  output logic                               out_rd_valid,
  output logic                               out_last,
  output logic [bpr_pkg::LEN_W-1:0]          out_transfer_count,
  output logic [bpr_pkg::FILL_W-1:0]         out_fill_level
);
  import bpr_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  bpr_ctrl #(
    .MAX_BURST (MAX_BURST)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .func    (in_func),
    .req_len (in_req_len),
    .stat    (stat),
    .cmd     (cmd)
  );

  bpr_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .wr_byte            (in_wr_byte),
    .stat               (stat),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_rd_data        (out_rd_data),
    .out_rd_valid       (out_rd_valid),
    .out_last           (out_last),
    .out_transfer_count (out_transfer_count),
    .out_fill_level     (out_fill_level)
  );

endmodule

`default_nettype wire

### design/bpr_checker.sv
// Port-level checker for the byte pipe, bound to the top level.
// Depends on bpr_pkg and byte_pipe_ring_fifo_unit.
`timescale 1ns / 1ps
`default_nettype none

module bpr_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          out_strobe,
  input wire logic [bpr_pkg::STATUS_W-1:0]  out_status,
  input wire logic [bpr_pkg::BYTE_W-1:0]    out_rd_data,
  input wire logic                          out_rd_valid,
  input wire logic                          out_last
);
  import bpr_pkg::*;

  // every taken request answers on the next cycle
  a_req_answers: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_strobe)
    else $error("request taken without a result next cycle");

  // a result only follows a taken request or a burst cycle
  a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy) || $past(busy))
    else $error("result without a request");

  // an unfinished burst continues on the very next cycle
  a_burst_runs: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe && out_rd_valid)
    else $error("burst broken before its last byte");

  // data bytes always come with success, and no byte means zero data
  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_rd_valid ? (out_status == ST_OK) : (out_rd_data == '0)))
    else $error("bad status or data on result");

endmodule

bind byte_pipe_ring_fifo_unit bpr_checker u_bpr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_strobe   (out_strobe),
  .out_status   (out_status),
  .out_rd_data  (out_rd_data),
  .out_rd_valid (out_rd_valid),
  .out_last     (out_last)
);

`default_nettype wire
